### rtl/ipv6tap_pkg.sv
// Package for the IPv6 text address parser: widths, character codes, hex decode.
`default_nettype none
package ipv6tap_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned GroupW   = 16;
  localparam int unsigned NumGroups = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned HalfW    = 64;

  localparam logic [CharW-1:0] CharColon = 8'h3A;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowF  = 8'h66;
  localparam logic [CharW-1:0] CaseBit   = 8'h20;

  typedef logic [GroupW-1:0] group_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [CharW-1:0] c);
    hex_t                 h;
    logic [CharW-1:0]     l;
    logic [CharW-1:0]     diff;
    h    = '0;
    l    = c | CaseBit;
    diff = '0;
    if (c >= CharZero && c <= CharNine) begin
      diff    = c - CharZero;
      h.valid = 1'b1;
      h.value = diff[3:0];
    end else if (l >= CharLowA && l <= CharLowF) begin
      diff    = l - CharLowA + 8'd10;
      h.valid = 1'b1;
      h.value = diff[3:0];
    end
    return h;
  endfunction

endpackage
`default_nettype wire

### rtl/ipv6_text_address_parser.sv
// Top level of the IPv6 text address parser.
//
// Input channel: one ASCII character per transfer (character_i) with is_last_i
// on the final character of an address. Characters go into an input register,
// then the group accumulation step updates the parser state.
// Output channel: one transfer per address, on its last character: ok_o and the
// 128-bit address as address_high_o / address_low_o (all zero when ok_o is 0).
// Throughput: one character per cycle while the input channel is not stalled.
// The result becomes valid once the last character has passed the input register
// and then the result register.
// When the receiver stalls, the result register holds; characters that are not
// last still proceed, and a last character waits in the input register until
// the result register frees, which then stalls the input channel.
// Reset clears the input and result valids and the parser state; after each
// result the parser state returns to its reset values.
`default_nettype none
module ipv6_text_address_parser (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [ipv6tap_pkg::CharW-1:0]        character_i,
  input  wire                                  is_last_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 ok_o,
  output logic [ipv6tap_pkg::HalfW-1:0]        address_high_o,
  output logic [ipv6tap_pkg::HalfW-1:0]        address_low_o
);
  import ipv6tap_pkg::*;

  logic              vld_q;
  logic [CharW-1:0]  char_q;
  logic              last_q;

  group_t            store_q [NumGroups];
  group_t            store_d [NumGroups];
  logic [CountW-1:0] cnt_q, cnt_d;
  group_t            val_q, val_d;
  logic              dig_q, dig_d;
  logic              gap_q, gap_d;
  logic [CountW-1:0] gpos_q, gpos_d;
  logic              pcol_q, pcol_d;
  logic              err_q, err_d;

  group_t            fin_store [NumGroups];
  logic [CountW-1:0] fin_cnt;
  logic              fin_err;
  logic [CountW-1:0] tail;
  logic [HalfW-1:0]  hi_d, lo_d;

  logic              out_free;
  logic              adv;
  hex_t              hx;
  logic              is_colon;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign adv        = vld_q && (!last_q || out_free);
  assign in_stall_o = vld_q && !adv;
  assign is_colon   = (char_q == CharColon);
  assign hx         = hex_decode(char_q);

  // per-character step
  always_comb begin
    cnt_d   = cnt_q;
    val_d   = val_q;
    dig_d   = dig_q;
    gap_d   = gap_q;
    gpos_d  = gpos_q;
    pcol_d  = pcol_q;
    err_d   = err_q;
    store_d = store_q;
    if (!err_q) begin
      if (is_colon) begin
        if (dig_q) begin
          if (cnt_q >= CountW'(NumGroups)) begin
            err_d = 1'b1;
          end else begin
            store_d[cnt_q[IdxW-1:0]] = val_q;
            cnt_d = cnt_q + 1'b1;
            val_d = '0;
            dig_d = 1'b0;
          end
        end else if (pcol_q) begin
          if (gap_q) begin
            err_d = 1'b1;
          end else begin
            gap_d  = 1'b1;
            gpos_d = cnt_q;
          end
        end
        pcol_d = 1'b1;
      end else if (!hx.valid) begin
        err_d = 1'b1;
      end else if (pcol_q && !gap_q && cnt_q == '0) begin
        err_d = 1'b1;
      end else if (val_q[GroupW-1:GroupW-4] != 4'd0) begin
        err_d = 1'b1;
      end else begin
        val_d  = {val_q[GroupW-5:0], hx.value};
        dig_d  = 1'b1;
        pcol_d = 1'b0;
      end
    end
  end

  // end-of-address checks and realignment around the gap
  always_comb begin
    fin_store = store_d;
    fin_cnt   = cnt_d;
    fin_err   = err_d;
    hi_d      = '0;
    lo_d      = '0;
    if (!err_d) begin
      if (dig_d) begin
        if (cnt_d >= CountW'(NumGroups)) begin
          fin_err = 1'b1;
        end else begin
          fin_store[cnt_d[IdxW-1:0]] = val_d;
          fin_cnt = cnt_d + 1'b1;
        end
      end else if (pcol_d && !(gap_d && gpos_d == cnt_d)) begin
        fin_err = 1'b1;
      end
    end
    if (!fin_err) begin
      if (gap_d ? (fin_cnt > CountW'(NumGroups - 1)) : (fin_cnt != CountW'(NumGroups))) begin
        fin_err = 1'b1;
      end
    end
    tail = fin_cnt - gpos_d;
    for (int p = 0; p < NumGroups; p++) begin
      group_t g;
      g = '0;
      if (!gap_d || (CountW'(p) < gpos_d)) begin
        g = fin_store[IdxW'(p)];
      end else if (({1'b0, CountW'(p)} + {1'b0, tail}) >= (CountW + 1)'(NumGroups)) begin
        g = fin_store[IdxW'(CountW'(p) + fin_cnt)];
      end
      if (p < NumGroups / 2) begin
        hi_d[HalfW-1-GroupW*p -: GroupW] = g;
      end else begin
        lo_d[HalfW-1-GroupW*(p-NumGroups/2) -: GroupW] = g;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= character_i;
      last_q <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      val_q  <= '0;
      dig_q  <= 1'b0;
      gap_q  <= 1'b0;
      gpos_q <= '0;
      pcol_q <= 1'b0;
      err_q  <= 1'b0;
    end else if (adv) begin
      if (last_q) begin
        cnt_q  <= '0;
        val_q  <= '0;
        dig_q  <= 1'b0;
        gap_q  <= 1'b0;
        gpos_q <= '0;
        pcol_q <= 1'b0;
        err_q  <= 1'b0;
      end else begin
        cnt_q  <= cnt_d;
        val_q  <= val_d;
        dig_q  <= dig_d;
        gap_q  <= gap_d;
        gpos_q <= gpos_d;
        pcol_q <= pcol_d;
        err_q  <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && !last_q) begin
      store_q <= store_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv && last_q) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      ok_o           <= !fin_err;
      address_high_o <= fin_err ? '0 : hi_d;
      address_low_o  <= fin_err ? '0 : lo_d;
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> address_high_o == '0 && address_low_o == '0)
    else $error("error result carries a nonzero address");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(NumGroups))
    else $error("group count above eight");

  a_gap_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q |-> gpos_q <= cnt_q)
    else $error("gap position beyond group count");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_q |=> cnt_q == '0 && !err_q && !gap_q && !dig_q && out_valid_o)
    else $error("state not cleared after final character");

endmodule
`default_nettype wire

### sim/tb_top.sv
// Testbench for the IPv6 text address parser: random and directed text, with a scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import ipv6tap_pkg::*;

  localparam int HoldCycles  = 200;
  localparam int LimitCycles = 400000;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } char_xfer_t;

  typedef struct packed {
    logic             ok;
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
  } addr_result_t;

  typedef enum int {MutReplace, MutColon, MutDrop} mutation_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [CharW-1:0] character_i = '0;
  logic             is_last_i   = 1'b0;
  logic             out_stall_i = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             ok_o;
  logic [HalfW-1:0] address_high_o;
  logic [HalfW-1:0] address_low_o;

  ipv6_text_address_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .character_i    (character_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .address_high_o (address_high_o),
    .address_low_o  (address_low_o)
  );

  always #5 clk_i = ~clk_i;

  char_xfer_t       char_q[$];
  addr_result_t     addr_expect_q[$];
  logic [CharW-1:0] text_q[$];
  char_xfer_t       next_char;
  int               send_idle_pct = 11;
  int               recv_idle_pct = 50;
  int               hold_reqs     = 0;
  int               holds_taken;
  int               hold_left;
  int               fail_count    = 0;
  int               cycle_count   = 0;

  // parser shadow state
  logic [GroupW-1:0] grp_store [NumGroups];
  logic [CountW-1:0] grp_cnt;
  logic [CountW-1:0] gap_pos;
  logic [GroupW-1:0] grp_val;
  logic              digits_seen;
  logic              gap_seen;
  logic              prev_colon;
  logic              err_seen;

  function automatic int nibble_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] lc;
    lc = c | CaseBit;
    if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
    if (lc >= CharLowA && lc <= CharLowF) return int'(lc - CharLowA) + 10;
    return -1;
  endfunction

  task automatic clear_parser();
    for (int i = 0; i < NumGroups; i++) grp_store[i] = '0;
    grp_cnt     = '0;
    gap_pos     = '0;
    grp_val     = '0;
    digits_seen = 1'b0;
    gap_seen    = 1'b0;
    prev_colon  = 1'b0;
    err_seen    = 1'b0;
  endtask

  task automatic seal_group();
    if (grp_cnt >= NumGroups) begin
      err_seen = 1'b1;
      return;
    end
    grp_store[grp_cnt[IdxW-1:0]] = grp_val;
    grp_cnt     = grp_cnt + 1'b1;
    grp_val     = '0;
    digits_seen = 1'b0;
  endtask

  task automatic parse_char(input logic [CharW-1:0] c);
    int d;
    if (err_seen) return;
    if (c == CharColon) begin
      if (digits_seen) begin
        seal_group();
      end else if (prev_colon) begin
        if (gap_seen) begin
          err_seen = 1'b1;
        end else begin
          gap_seen = 1'b1;
          gap_pos  = grp_cnt;
        end
      end
      prev_colon = 1'b1;
      return;
    end
    d = nibble_of(c);
    if (d < 0 || (prev_colon && !gap_seen && grp_cnt == 0) || grp_val[15:12] != 0) begin
      err_seen = 1'b1;
      return;
    end
    grp_val     = {grp_val[11:0], d[3:0]};
    digits_seen = 1'b1;
    prev_colon  = 1'b0;
  endtask

  task automatic emit_address();
    addr_result_t      r;
    int                tail;
    logic [GroupW-1:0] g;
    if (!err_seen) begin
      if (digits_seen) seal_group();
      else if (prev_colon && !(gap_seen && gap_pos == grp_cnt)) err_seen = 1'b1;
    end
    if (!err_seen && (gap_seen ? grp_cnt > 7 : grp_cnt != NumGroups)) err_seen = 1'b1;
    r = '0;
    if (!err_seen) begin
      r.ok = 1'b1;
      tail = int'(grp_cnt) - int'(gap_pos);
      for (int p = 0; p < NumGroups; p++) begin
        g = '0;
        if (!gap_seen || p < gap_pos) g = grp_store[p];
        else if (p >= NumGroups - tail) g = grp_store[int'(gap_pos) + p - (NumGroups - tail)];
        if (p < 4) r.hi = {r.hi[HalfW-GroupW-1:0], g};
        else r.lo = {r.lo[HalfW-GroupW-1:0], g};
      end
    end
    addr_expect_q.push_back(r);
    clear_parser();
  endtask

  initial clear_parser();

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      character_i <= '0;
      is_last_i   <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_char(character_i);
        if (is_last_i) emit_address();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_char = char_q.pop_front();
          in_valid_i  <= 1'b1;
          character_i <= next_char.ch;
          is_last_i   <= next_char.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_address();
    addr_result_t e;
    if (addr_expect_q.size() == 0) begin
      $display("%0t: result with none expected, ok %0b high %h low %h",
               $time, ok_o, address_high_o, address_low_o);
      fail_count++;
      return;
    end
    e = addr_expect_q.pop_front();
    if (ok_o !== e.ok) begin
      $display("%0t: ok expected %0b got %0b", $time, e.ok, ok_o);
      fail_count++;
    end
    if (address_high_o !== e.hi) begin
      $display("%0t: address_high expected %h got %h", $time, e.hi, address_high_o);
      fail_count++;
    end
    if (address_low_o !== e.lo) begin
      $display("%0t: address_low expected %h got %h", $time, e.lo, address_low_o);
      fail_count++;
    end
  endtask

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      holds_taken <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_address();
      if (holds_taken != hold_reqs) begin
        holds_taken <= holds_taken + 1;
        hold_left   <= HoldCycles;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] v);
    if (v < 10) return CharZero + v;
    if ($urandom_range(1)) return CharLowA + v - 8'd10;
    return (CharLowA & ~CaseBit) + v - 8'd10;
  endfunction

  task automatic queue_text();
    char_xfer_t x;
    for (int i = 0; i < text_q.size(); i++) begin
      x.ch   = text_q[i];
      x.last = (i == text_q.size() - 1);
      char_q.push_back(x);
    end
  endtask

  task automatic load_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic put_group();
    int                r;
    int                nd;
    logic [GroupW-1:0] val;
    r = $urandom_range(99);
    if (r < 3) begin
      text_q.push_back(hex_char(4'($urandom_range(1, 15))));  // fifth digit, too large
      nd  = 4;
      val = GroupW'($urandom);
    end else if (r < 10) begin
      nd  = 4;
      val = '1;
    end else if (r < 16) begin
      nd  = $urandom_range(1, 4);
      val = '0;
    end else begin
      nd  = $urandom_range(1, 4);
      val = GroupW'($urandom & ((32'd1 << (4 * nd)) - 1));
      if (r < 24) nd += $urandom_range(1, 2);  // leading zeros
    end
    for (int i = nd - 1; i >= 0; i--) text_q.push_back(hex_char(i < 4 ? val[4*i +: 4] : 4'h0));
  endtask

  task automatic make_address();
    int        shape;
    int        ngroups;
    int        gap_at;
    int        pos;
    bit        use_gap;
    mutation_e mut;
    text_q.delete();
    shape = $urandom_range(99);
    if (shape < 5) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(CharW'($urandom_range(255)));
      return;
    end
    use_gap = 1'($urandom_range(1));
    ngroups = use_gap ? $urandom_range(0, 7) : NumGroups;
    if (shape < 12) begin
      if (!use_gap && $urandom_range(1)) ngroups = 7;
      else ngroups++;
    end
    gap_at = $urandom_range(0, ngroups);
    for (int i = 0; i < ngroups; i++) begin
      if (use_gap && i == gap_at) begin
        text_q.push_back(CharColon);
        text_q.push_back(CharColon);
      end else if (i > 0) begin
        text_q.push_back(CharColon);
      end
      put_group();
    end
    if (use_gap && gap_at == ngroups) begin
      text_q.push_back(CharColon);
      text_q.push_back(CharColon);
    end
    if (shape >= 12 && shape < 24) begin
      pos = $urandom_range(text_q.size() - 1);
      mut = mutation_e'($urandom_range(2));
      case (mut)
        MutReplace: text_q[pos] = CharW'($urandom_range(255));
        MutColon:   text_q.insert(pos, CharColon);
        default:    if (text_q.size() > 1) text_q.delete(pos);
      endcase
    end
  endtask

  task automatic gen_addresses(input int min_chars, input int min_addrs);
    int nchars;
    int naddrs;
    nchars = 0;
    naddrs = 0;
    while (nchars < min_chars || naddrs < min_addrs) begin
      make_address();
      nchars += text_q.size();
      naddrs++;
      queue_text();
    end
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || in_valid_i || addr_expect_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    string directed_txt[] = '{"::", ":::", ":1", "1:", "G:1", "10000", "0", "1::", "fF::"};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_txt[i]) begin
      load_string(directed_txt[i]);
      queue_text();
    end
    text_q = '{8'h00};
    queue_text();
    text_q = '{8'hFF};
    queue_text();
    gen_addresses(140, 4);
    wait_drained();

    // long receiver hold-off while characters keep coming
    hold_reqs++;
    gen_addresses(60, 2);
    wait_drained();

    send_idle_pct = 50;
    recv_idle_pct = 11;
    gen_addresses(140, 4);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_addresses(140, 4);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && addr_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/ipv6tap_pkg.sv
rtl/ipv6_text_address_parser.sv
sim/tb_top.sv
